// ----- rtl/core/tmg_pkg.sv -----
// Shared types, constants and helpers for the transform matrix generator.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none
package tmg_pkg;

  typedef enum logic [2:0] {
    OP_ROT_X     = 3'd0,
    OP_ROT_Y     = 3'd1,
    OP_ROT_Z     = 3'd2,
    OP_ROT_XYZ   = 3'd3,
    OP_SCALE     = 3'd4,
    OP_TRANSLATE = 3'd5
  } op_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_CORDIC, ST_CAP, ST_MUL1, ST_MUL2, ST_EMIT
  } back_state_t;

  localparam int TURN_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [23:0] ONE_Q16   = 24'sd65536;

  // One queued request: op plus the raw operands.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
  } req_t;

  // Result row as it leaves the back end.
  typedef struct packed {
    logic [1:0]         row;
    logic signed [23:0] c0;
    logic signed [23:0] c1;
    logic signed [23:0] c2;
    logic signed [23:0] c3;
    logic               last;
  } row_t;

  function automatic logic signed [33:0] atan_q20(input logic [4:0] i);
    case (i)
      5'd0:  atan_q20 = 34'sd47185920;
      5'd1:  atan_q20 = 34'sd27855475;
      5'd2:  atan_q20 = 34'sd14718068;
      5'd3:  atan_q20 = 34'sd7471121;
      5'd4:  atan_q20 = 34'sd3750058;
      5'd5:  atan_q20 = 34'sd1876857;
      5'd6:  atan_q20 = 34'sd938658;
      5'd7:  atan_q20 = 34'sd469357;
      5'd8:  atan_q20 = 34'sd234682;
      5'd9:  atan_q20 = 34'sd117342;
      5'd10: atan_q20 = 34'sd58671;
      5'd11: atan_q20 = 34'sd29335;
      5'd12: atan_q20 = 34'sd14668;
      5'd13: atan_q20 = 34'sd7334;
      5'd14: atan_q20 = 34'sd3667;
      5'd15: atan_q20 = 34'sd1833;
      5'd16: atan_q20 = 34'sd917;
      5'd17: atan_q20 = 34'sd458;
      5'd18: atan_q20 = 34'sd229;
      5'd19: atan_q20 = 34'sd115;
      5'd20: atan_q20 = 34'sd57;
      5'd21: atan_q20 = 34'sd29;
      5'd22: atan_q20 = 34'sd14;
      5'd23: atan_q20 = 34'sd7;
      default: atan_q20 = 34'sd0;
    endcase
  endfunction

  // Q.16 product rounded to nearest (floor of x+0.5).
  function automatic logic signed [18:0] qmul(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    logic signed [35:0] p;
    p = (a * b) + 36'sd32768;
    qmul = p[34:16];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tmg_front.sv -----
// Front end: accepts requests, drops unused op codes, pushes valid ones.
// Depends on tmg_pkg.
`default_nettype none
module tmg_front (
  input  wire logic          valid,
  output logic               ready,
  input  wire tmg_pkg::req_t req,
  output logic               push,
  output tmg_pkg::req_t      push_req,
  input  wire logic          q_full
);
  logic known;

  assign known    = (req.op <= tmg_pkg::OP_TRANSLATE);
  assign ready    = !q_full;
  assign push     = valid && ready && known;
  assign push_req = req;
endmodule
`default_nettype wire

// ----- rtl/core/tmg_queue.sv -----
// Short request queue between the front and back ends.
// Depends on tmg_pkg.
`default_nettype none
module tmg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tmg_pkg::req_t din,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output tmg_pkg::req_t      dout
);
  tmg_pkg::req_t mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;

  assign full      = (cnt == 3'd4);
  assign not_empty = (cnt != 3'd0);
  assign dout      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/tmg_back.sv -----
// Back end: sine/cosine by iterative CORDIC, products, row emission.
// Depends on tmg_pkg.
`default_nettype none
module tmg_back #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire tmg_pkg::req_t q_req,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tmg_pkg::row_t      out_row
);
  localparam logic signed [17:0] TURN      = 18'(tmg_pkg::TURN_UNITS);
  localparam logic signed [17:0] TWO_TURNS = 18'(2 * tmg_pkg::TURN_UNITS);
  localparam logic [14:0] Q1 = 15'(tmg_pkg::QUARTER_UNITS);
  localparam logic [14:0] Q2 = 15'(2 * tmg_pkg::QUARTER_UNITS);
  localparam logic [14:0] Q3 = 15'(3 * tmg_pkg::QUARTER_UNITS);

  tmg_pkg::back_state_t st, st_next;
  tmg_pkg::req_t cur;
  logic [1:0] ang_sel;       // which angle is in the CORDIC
  logic [4:0] it;
  logic signed [33:0] x, y, z;
  logic [1:0] quad;
  logic signed [17:0] cs [3];
  logic signed [17:0] sn [3];
  logic signed [18:0] m_crcy, m_srcy, m_spcr, m_spsr, m_cpsr, m_cpcr, m_spcy,
                      m_cpcy, m_sp_cr_sy, m_sp_sr_sy, m_cp_cr_sy, m_cp_sr_sy;
  logic [1:0] row;
  logic [1:0] nrows;
  logic signed [33:0] dx, dy, at;
  logic signed [17:0] ang;
  logic signed [17:0] rr;
  logic [14:0] red;
  logic signed [17:0] cc, ss;
  logic signed [25:0] e0, e1, e2, e3;

  function automatic logic signed [17:0] clamp16(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd65536) clamp16 = 18'sd65536;
    else if (t < -34'sd65536) clamp16 = -18'sd65536;
    else clamp16 = t[17:0];
  endfunction

  function automatic logic signed [23:0] sat(input logic signed [25:0] v);
    if (v > 26'sd8388607) sat = 24'sh7FFFFF;
    else if (v < -26'sd8388608) sat = 24'sh800000;
    else sat = v[23:0];
  endfunction

  always_comb begin
    case (ang_sel)
      2'd0: ang = {{2{cur.ax[15]}}, cur.ax};
      2'd1: ang = {{2{cur.ay[15]}}, cur.ay};
      default: ang = {{2{cur.az[15]}}, cur.az};
    endcase
    rr = (ang < 0) ? ang + TWO_TURNS : ang;
    if (rr >= TURN) rr = rr - TURN;
    if (rr >= TURN) rr = rr - TURN;
    red = rr[14:0];
    dx = y >>> it;
    dy = x >>> it;
    at = tmg_pkg::atan_q20(it);
    cc = clamp16(x);
    ss = clamp16(y);
  end

  assign pop = (st == tmg_pkg::ST_IDLE) && q_valid;
  assign out_valid = (st == tmg_pkg::ST_EMIT);

  always_comb begin
    st_next = st;
    case (st)
      tmg_pkg::ST_IDLE:   if (q_valid) st_next = tmg_pkg::ST_LOAD;
      tmg_pkg::ST_LOAD:   st_next = tmg_pkg::ST_CORDIC;
      tmg_pkg::ST_CORDIC: begin
        if (it == 5'(TRIG_ITERATIONS - 1)) begin
          if (cur.op == tmg_pkg::OP_ROT_XYZ && ang_sel != 2'd2)
            st_next = tmg_pkg::ST_LOAD;
          else st_next = tmg_pkg::ST_CAP;
        end
      end
      // The final sine and cosine are written into cs/sn during this cycle.
      tmg_pkg::ST_CAP: begin
        if (cur.op == tmg_pkg::OP_ROT_XYZ) st_next = tmg_pkg::ST_MUL1;
        else st_next = tmg_pkg::ST_EMIT;
      end
      tmg_pkg::ST_MUL1:   st_next = tmg_pkg::ST_MUL2;
      tmg_pkg::ST_MUL2:   st_next = tmg_pkg::ST_EMIT;
      tmg_pkg::ST_EMIT:   if (out_ready && row == nrows) st_next = tmg_pkg::ST_IDLE;
      default:            st_next = tmg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= tmg_pkg::ST_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    case (st)
      tmg_pkg::ST_IDLE: if (q_valid) begin
        cur <= q_req;
        row <= 2'd0;
        nrows <= (q_req.op == tmg_pkg::OP_TRANSLATE) ? 2'd3 : 2'd2;
        case (q_req.op)
          tmg_pkg::OP_ROT_Y: ang_sel <= 2'd1;
          tmg_pkg::OP_ROT_Z: ang_sel <= 2'd2;
          default: ang_sel <= 2'd0;
        endcase
        if (q_req.op == tmg_pkg::OP_SCALE || q_req.op == tmg_pkg::OP_TRANSLATE)
          it <= 5'(TRIG_ITERATIONS - 1);
        else it <= '0;
      end
      tmg_pkg::ST_LOAD: begin
        quad <= (red >= Q3) ? 2'd3 : (red >= Q2) ? 2'd2 :
                (red >= Q1) ? 2'd1 : 2'd0;
        x <= tmg_pkg::CORDIC_X0;
        y <= '0;
        z <= 34'(red - ((red >= Q3) ? Q3 : (red >= Q2) ?
             Q2 : (red >= Q1) ? Q1 : 15'd0)) <<< 14;
        it <= '0;
        if (cur.op == tmg_pkg::OP_SCALE || cur.op == tmg_pkg::OP_TRANSLATE)
          it <= 5'(TRIG_ITERATIONS - 1);
      end
      tmg_pkg::ST_CORDIC: begin
        if (z >= 0) begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end
        it <= it + 5'd1;
        if (it == 5'(TRIG_ITERATIONS - 1)) begin
          ang_sel <= ang_sel + 2'd1;
          // Results land next cycle from final x,y; capture on that edge instead.
        end
      end
      tmg_pkg::ST_MUL1: begin
        m_crcy <= tmg_pkg::qmul(cs[2], cs[1]);
        m_srcy <= tmg_pkg::qmul(sn[2], cs[1]);
        m_spcr <= tmg_pkg::qmul(sn[0], cs[2]);
        m_spsr <= tmg_pkg::qmul(sn[0], sn[2]);
        m_cpsr <= tmg_pkg::qmul(cs[0], sn[2]);
        m_cpcr <= tmg_pkg::qmul(cs[0], cs[2]);
        m_spcy <= tmg_pkg::qmul(sn[0], cs[1]);
        m_cpcy <= tmg_pkg::qmul(cs[0], cs[1]);
      end
      tmg_pkg::ST_MUL2: begin
        m_sp_cr_sy <= tmg_pkg::qmul(m_spcr[17:0], sn[1]);
        m_sp_sr_sy <= tmg_pkg::qmul(m_spsr[17:0], sn[1]);
        m_cp_cr_sy <= tmg_pkg::qmul(m_cpcr[17:0], sn[1]);
        m_cp_sr_sy <= tmg_pkg::qmul(m_cpsr[17:0], sn[1]);
      end
      tmg_pkg::ST_EMIT: if (out_ready) row <= row + 2'd1;
      default: ;
    endcase
  end

  // Capture sin/cos after the final CORDIC step, applying the quadrant.
  logic cap;
  logic [1:0] cap_sel;
  always_ff @(posedge clk) begin
    if (rst) cap <= 1'b0;
    else cap <= (st == tmg_pkg::ST_CORDIC) && (it == 5'(TRIG_ITERATIONS - 1));
    cap_sel <= ang_sel;
    if (cap) begin
      case (quad)
        2'd1: begin cs[cap_sel] <= -ss; sn[cap_sel] <= cc; end
        2'd2: begin cs[cap_sel] <= -cc; sn[cap_sel] <= -ss; end
        2'd3: begin cs[cap_sel] <= ss;  sn[cap_sel] <= -cc; end
        default: begin cs[cap_sel] <= cc; sn[cap_sel] <= ss; end
      endcase
    end
  end

  always_comb begin
    logic signed [25:0] one, c, s;
    logic [1:0] k;
    k = (cur.op == tmg_pkg::OP_ROT_X) ? 2'd0 : (cur.op == tmg_pkg::OP_ROT_Y) ?
        2'd1 : 2'd2;
    one = 26'(tmg_pkg::ONE_Q16);
    c = 26'(cs[k]);
    s = 26'(sn[k]);
    e0 = '0; e1 = '0; e2 = '0; e3 = '0;
    case (cur.op)
      tmg_pkg::OP_ROT_X: case (row)
        2'd0: e0 = one;
        2'd1: begin e1 = c; e2 = s; end
        default: begin e1 = -s; e2 = c; end
      endcase
      tmg_pkg::OP_ROT_Y: case (row)
        2'd0: begin e0 = c; e2 = -s; end
        2'd1: e1 = one;
        default: begin e0 = s; e2 = c; end
      endcase
      tmg_pkg::OP_ROT_Z: case (row)
        2'd0: begin e0 = c; e1 = s; end
        2'd1: begin e0 = -s; e1 = c; end
        default: e2 = one;
      endcase
      tmg_pkg::OP_ROT_XYZ: case (row)
        2'd0: begin e0 = 26'(m_crcy); e1 = 26'(m_srcy); e2 = -26'(sn[1]); end
        2'd1: begin
          e0 = 26'(m_sp_cr_sy) - 26'(m_cpsr);
          e1 = 26'(m_sp_sr_sy) + 26'(m_cpcr);
          e2 = 26'(m_spcy);
        end
        default: begin
          e0 = 26'(m_cp_cr_sy) + 26'(m_spsr);
          e1 = 26'(m_cp_sr_sy) - 26'(m_spcr);
          e2 = 26'(m_cpcy);
        end
      endcase
      tmg_pkg::OP_SCALE: case (row)
        2'd0: e0 = 26'(cur.vx);
        2'd1: e1 = 26'(cur.vy);
        default: e2 = 26'(cur.vz);
      endcase
      default: case (row)
        2'd0: e0 = one;
        2'd1: e1 = one;
        2'd2: e2 = one;
        default: begin
          e0 = 26'(cur.vx); e1 = 26'(cur.vy); e2 = 26'(cur.vz); e3 = one;
        end
      endcase
    endcase
    out_row.row  = row;
    out_row.c0   = sat(e0);
    out_row.c1   = sat(e1);
    out_row.c2   = sat(e2);
    out_row.c3   = sat(e3);
    out_row.last = (row == nrows);
  end
endmodule
`default_nettype wire

// ----- rtl/core/transform_matrix_generator.sv -----
// Top level of the transform matrix generator.
// Depends on tmg_pkg, tmg_front, tmg_queue and tmg_back.
//
//  Channel | Handshake      | Beat carries
//  in      | valid / ready  | op, angle_x..z, value_x..z
//  out     | out_valid/rdy  | row_index, col_zero..three, last_row
//
// Back end time for rotations is set by the one shared CORDIC iterating
// one step per cycle, for each of the three angles in turn on XYZ.
// A four-entry queue keeps the input accepting while the back end works.
// Reset (rst, synchronous) empties the queue and idles the back end.
`default_nettype none
module transform_matrix_generator #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    ready,
  input  wire logic [2:0]         op,
  input  wire logic signed [15:0] angle_x,
  input  wire logic signed [15:0] angle_y,
  input  wire logic signed [15:0] angle_z,
  input  wire logic signed [23:0] value_x,
  input  wire logic signed [23:0] value_y,
  input  wire logic signed [23:0] value_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              row_index,
  output logic signed [23:0]      col_zero,
  output logic signed [23:0]      col_one,
  output logic signed [23:0]      col_two,
  output logic signed [23:0]      col_three,
  output logic                    last_row
);
  tmg_pkg::req_t req, push_req, q_dout;
  tmg_pkg::row_t row;
  logic push, q_full, q_ne, pop;

  assign req = '{op: op, ax: angle_x, ay: angle_y, az: angle_z,
                 vx: value_x, vy: value_y, vz: value_z};

  tmg_front u_front (.valid, .ready, .req, .push, .push_req, .q_full);
  tmg_queue u_queue (.clk, .rst, .push, .din(push_req), .full(q_full), .pop,
                     .not_empty(q_ne), .dout(q_dout));
  tmg_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk, .rst, .q_valid(q_ne), .q_req(q_dout), .pop, .out_valid, .out_ready,
    .out_row(row));

  assign row_index = row.row;
  assign col_zero  = row.c0;
  assign col_one   = row.c1;
  assign col_two   = row.c2;
  assign col_three = row.c3;
  assign last_row  = row.last;
endmodule
`default_nettype wire

// ----- rtl/core/tmg_checker.sv -----
// Port-level checker for the transform matrix generator, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module tmg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] row_index,
  input wire logic       last_row,
  input wire logic [23:0] col_three
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_index))
    else $error("result beat dropped");
  a_next_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_row |=> out_valid && row_index == $past(row_index) + 2'd1)
    else $error("row sequence broken");
  a_col3: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_index != 2'd3 |-> col_three == 24'd0)
    else $error("col_three nonzero");
endmodule

bind transform_matrix_generator tmg_checker u_tmg_checker (
  .clk, .rst, .out_valid, .out_ready, .row_index, .last_row, .col_three);
`default_nettype wire

// ----- tb/transform_matrix_generator_test.sv -----
// Self-checking testbench for transform_matrix_generator: rotation, scale and
// translate requests, rows predicted in the bench and compared beat by beat.
// Depends on tmg_pkg and the transform_matrix_generator RTL.
`timescale 1ns / 100ps
`default_nettype none
module transform_matrix_generator_test;

  localparam int ITERS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [1:0] row;
    logic signed [23:0] c0, c1, c2, c3;
    logic last;
  } matrix_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [2:0] op = '0;
  logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [23:0] value_x = '0, value_y = '0, value_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row_index;
  logic signed [23:0] col_zero, col_one, col_two, col_three;
  logic last_row;

  matrix_row_t expected_rows[$];
  int errors = 0;
  int rows_seen = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit hold_off = 1'b0;

  always #6 clk = ~clk;

  transform_matrix_generator #(.TRIG_ITERATIONS(ITERS)) dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .op(op),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .value_x(value_x), .value_y(value_y), .value_z(value_z),
    .out_valid(out_valid), .out_ready(out_ready), .row_index(row_index),
    .col_zero(col_zero), .col_one(col_one), .col_two(col_two),
    .col_three(col_three), .last_row(last_row)
  );

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    return floor_shift(a * b + 32768, 16);
  endfunction

  function automatic longint round_unit(longint v30);
    longint v;
    v = floor_shift(v30 + 8192, 14);
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7};
    return tbl[i];
  endfunction

  // Quadrant reduction, then CORDIC on the residue within the first quadrant.
  task automatic degree_sincos(input longint ang, output longint c, output longint s);
    longint r, q, x, y, z, dx, dy, cc, ss;
    r = ang;
    if (r < 0) r += 2 * 23040;
    r = r % 23040;
    q = r / 5760;
    x = 652032874;
    y = 0;
    z = (r - q * 5760) * 16384;
    for (int i = 0; i < ITERS && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    cc = round_unit(x);
    ss = round_unit(y);
    case (q)
      1: begin c = -ss; s = cc; end
      2: begin c = -cc; s = -ss; end
      3: begin c = ss; s = -cc; end
      default: begin c = cc; s = ss; end
    endcase
  endtask

  function automatic void push_row(int k, longint a, longint b, longint c,
                                   longint d, bit last);
    matrix_row_t r;
    r.row = k[1:0];
    r.c0 = 24'(clamp24(a));
    r.c1 = 24'(clamp24(b));
    r.c2 = 24'(clamp24(c));
    r.c3 = 24'(clamp24(d));
    r.last = last;
    expected_rows.push_back(r);
  endfunction

  task automatic predict_matrix(input logic [2:0] code, input logic signed [15:0] ax,
      input logic signed [15:0] ay, input logic signed [15:0] az,
      input logic signed [23:0] vx, input logic signed [23:0] vy,
      input logic signed [23:0] vz);
    longint c, s, cp, sp, cy, sy, cr, sr;
    case (code)
      tmg_pkg::OP_ROT_X: begin
        degree_sincos(ax, c, s);
        push_row(0, 65536, 0, 0, 0, 0);
        push_row(1, 0, c, s, 0, 0);
        push_row(2, 0, -s, c, 0, 1);
      end
      tmg_pkg::OP_ROT_Y: begin
        degree_sincos(ay, c, s);
        push_row(0, c, 0, -s, 0, 0);
        push_row(1, 0, 65536, 0, 0, 0);
        push_row(2, s, 0, c, 0, 1);
      end
      tmg_pkg::OP_ROT_Z: begin
        degree_sincos(az, c, s);
        push_row(0, c, s, 0, 0, 0);
        push_row(1, -s, c, 0, 0, 0);
        push_row(2, 0, 0, 65536, 0, 1);
      end
      tmg_pkg::OP_ROT_XYZ: begin
        degree_sincos(ax, cp, sp);
        degree_sincos(ay, cy, sy);
        degree_sincos(az, cr, sr);
        push_row(0, mul_q16(cr, cy), mul_q16(sr, cy), -sy, 0, 0);
        push_row(1, mul_q16(mul_q16(sp, cr), sy) - mul_q16(cp, sr),
                 mul_q16(mul_q16(sp, sr), sy) + mul_q16(cp, cr),
                 mul_q16(sp, cy), 0, 0);
        push_row(2, mul_q16(mul_q16(cp, cr), sy) + mul_q16(sp, sr),
                 mul_q16(mul_q16(cp, sr), sy) - mul_q16(sp, cr),
                 mul_q16(cp, cy), 0, 1);
      end
      tmg_pkg::OP_SCALE: begin
        push_row(0, vx, 0, 0, 0, 0);
        push_row(1, 0, vy, 0, 0, 0);
        push_row(2, 0, 0, vz, 0, 1);
      end
      tmg_pkg::OP_TRANSLATE: begin
        push_row(0, 65536, 0, 0, 0, 0);
        push_row(1, 0, 65536, 0, 0, 0);
        push_row(2, 0, 0, 65536, 0, 0);
        push_row(3, vx, vy, vz, 65536, 1);
      end
      default: ;
    endcase
  endtask

  // Offers one request after a random gap and holds it until the beat is taken.
  // Valid drops only when a gap follows, so back-to-back beats keep it high.
  task automatic send_request(input logic [2:0] code, input logic signed [15:0] ax,
      input logic signed [15:0] ay, input logic signed [15:0] az,
      input logic signed [23:0] vx, input logic signed [23:0] vy,
      input logic signed [23:0] vz, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    op <= code;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    value_x <= vx; value_y <= vy; value_z <= vz;
    predict_matrix(code, ax, ay, az, vx, vy, vz);
    do @(posedge clk); while (!ready);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 23040) - 11520);
      1: return 16'($urandom_range(0, 4) * 5760);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_value();
    return $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 262144) - 131072);
  endfunction

  task automatic send_random(input logic [2:0] code, input bit no_gap = 1'b0);
    send_request(code, rand_angle(), rand_angle(), rand_angle(),
                 rand_value(), rand_value(), rand_value(), no_gap);
  endtask

  task automatic test_single_axis();
    logic signed [15:0] corner[8] = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280,
      16'sd23040, -16'sd5760, 16'sh7FFF, 16'sh8000};
    for (int i = 0; i < 8; i++)
      send_request(tmg_pkg::OP_ROT_X + 3'(i % 3), corner[i], corner[7 - i], corner[i],
                   0, 0, 0);
    send_request(tmg_pkg::OP_ROT_Y, 16'sd2880, 16'sd1920, 0, 0, 0, 0);
  endtask

  task automatic test_euler();
    send_request(tmg_pkg::OP_ROT_XYZ, 0, 0, 0, 0, 0, 0);
    send_request(tmg_pkg::OP_ROT_XYZ, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0, 0);
    send_request(tmg_pkg::OP_ROT_XYZ, 16'sd1920, 16'sd2880, -16'sd960, 0, 0, 0);
    send_request(tmg_pkg::OP_ROT_XYZ, 16'sd30000, -16'sd30000, 16'sd5760, 0, 0, 0);
  endtask

  task automatic test_scale_translate();
    send_request(tmg_pkg::OP_SCALE, 0, 0, 0, 24'sh7FFFFF, 24'sh800000, 0);
    send_request(tmg_pkg::OP_SCALE, 0, 0, 0, 24'sd65536, 24'sd65536, 24'sd65536);
    send_request(tmg_pkg::OP_SCALE, 16'shFFFF, 16'shFFFF, 16'shFFFF, -24'sd1, 24'sd1,
                 -24'sd1);
    send_request(tmg_pkg::OP_TRANSLATE, 0, 0, 0, 24'sh800000, 24'sh7FFFFF, 24'sh555555);
    send_request(tmg_pkg::OP_TRANSLATE, 16'sh1234, 0, 0, -24'sd1, 0, 24'shAAAAAA);
  endtask

  task automatic test_unused_codes();
    send_request(OP_SPARE_A, 16'sd100, 16'sd200, 16'sd300, 24'sd1, 24'sd2, 24'sd3);
    send_request(tmg_pkg::OP_SCALE, 0, 0, 0, 24'sd7, 24'sd8, 24'sd9);
    send_request(OP_SPARE_B, 16'sh8000, 16'sh7FFF, 0, 24'sh800000, 0, 0);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(0, 24) == 0) send_random($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B);
      else send_random(3'($urandom_range(0, 5)));
    end
  endtask

  // The result side stalls for a long stretch while requests keep coming back to back.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 10; i++) send_random(3'($urandom_range(0, 5)), 1'b1);
    hold_off = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_axis();
    test_euler();
    test_scale_translate();
    test_unused_codes();
    fork
      test_backpressure();
      begin
        @(posedge clk);
        wait (hold_off == 1'b0);
      end
    join
    test_random_mix();
    valid <= 1'b0;
    wait (expected_rows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests covering every op, wrapped angles and spare codes;", items_sent);
    $display("checked %0d matrix rows, including a long output stall.", rows_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, a held-off stretch on request, otherwise free running.
  initial begin
    int stall;
    int stall_count;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        stall_count = 0;
        out_ready <= 1'b0;
        while (stall_count < 300) begin
          @(posedge clk);
          stall_count++;
        end
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    matrix_row_t exp_row;
    if (!rst && out_valid && out_ready) begin
      rows_seen++;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row beat, actual row %0d", $time, row_index);
        errors++;
      end else begin
        exp_row = expected_rows.pop_front();
        if (row_index !== exp_row.row || col_zero !== exp_row.c0 ||
            col_one !== exp_row.c1 || col_two !== exp_row.c2 ||
            col_three !== exp_row.c3 || last_row !== exp_row.last) begin
          $display("%0t: row mismatch expected %0d %0d %0d %0d %0d last %0b", $time,
                   exp_row.row, exp_row.c0, exp_row.c1, exp_row.c2, exp_row.c3,
                   exp_row.last);
          $display("%0t:              actual %0d %0d %0d %0d %0d last %0b", $time,
                   row_index, col_zero, col_one, col_two, col_three, last_row);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((valid && ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end
endmodule
`default_nettype wire
